// ===== sv/line_editor_with_echo_macros.svh =====
// Assertion macros shared by the line editor checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef LINE_EDITOR_WITH_ECHO_MACROS_SVH
`define LINE_EDITOR_WITH_ECHO_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line editor check failed");

// Next-cycle implication, disabled during reset
`define LED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line editor check failed");

`endif

// ===== sv/led_pkg.sv =====
// Shared types and constants for the line editor.
// No dependencies; used by every RTL file of the block except led_ram.
package led_pkg;

  // Build-time line store size
  localparam int LINE_MAX_DEF = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int LIM_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CR_DROP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd32;

  // Character codes
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_DEL = 8'd127;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ECHO_CR,
    S_ECHO_C,
    S_STORE,
    S_ERASE_BS1,
    S_ERASE_SP,
    S_ERASE_BS2,
    S_LINE_RD,
    S_LINE_OUT
  } state_t;

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SEL_BS,
    SEL_SP,
    SEL_CR,
    SEL_CUR,
    SEL_LINE
  } out_sel_t;

  typedef struct packed {
    logic     accept;    // latch rx_byte
    logic     to_lf;     // turn the held CR into LF
    logic     len_dec;   // erase the last stored byte
    logic     store;     // store held byte or mark overflow
    logic     clear;     // empty the line, drop overflow mark
    logic     line_start;// rewind the line read index
    logic     rd_en;     // read the line store
    logic     advance;   // step the line read index
    logic     load;      // load the output register
    out_sel_t sel;
    logic     last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_esc;
    logic is_erase;
    logic is_cr;
    logic is_lf;
    logic len_zero;
    logic room;
    logic echo;
    logic crlf;
    logic can_load;
    logic line_end;
  } dp_status_t;

endpackage

// ===== sv/led_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module led_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/led_ctrl.sv =====
// Sequencer of the line editor: decodes each byte and steps out its results.
// Depends on led_pkg; drives the datapath through ctrl_cmd_t.
module led_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  led_pkg::dp_status_t st,
  output led_pkg::ctrl_cmd_t  cmd
);

  led_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= led_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      led_pkg::S_IDLE: begin
        if (rx_valid) state_next = led_pkg::S_DECODE;
      end
      led_pkg::S_DECODE: begin
        if (st.is_esc) begin
          state_next = led_pkg::S_IDLE;
        end else if (st.is_erase) begin
          state_next = (!st.len_zero && st.echo) ? led_pkg::S_ERASE_BS1 : led_pkg::S_IDLE;
        end else if (st.is_cr && st.echo) begin
          state_next = led_pkg::S_ECHO_CR;
        end else if (st.is_cr && st.crlf) begin
          state_next = led_pkg::S_IDLE;
        end else begin
          state_next = st.echo ? led_pkg::S_ECHO_C : led_pkg::S_STORE;
        end
      end
      led_pkg::S_ECHO_CR: begin
        if (st.can_load) state_next = st.crlf ? led_pkg::S_IDLE : led_pkg::S_ECHO_C;
      end
      led_pkg::S_ECHO_C: begin
        if (st.can_load) state_next = led_pkg::S_STORE;
      end
      led_pkg::S_STORE: begin
        if (st.is_lf && (st.room || !st.len_zero)) state_next = led_pkg::S_LINE_RD;
        else state_next = led_pkg::S_IDLE;
      end
      led_pkg::S_ERASE_BS1: begin
        if (st.can_load) state_next = led_pkg::S_ERASE_SP;
      end
      led_pkg::S_ERASE_SP: begin
        if (st.can_load) state_next = led_pkg::S_ERASE_BS2;
      end
      led_pkg::S_ERASE_BS2: begin
        if (st.can_load) state_next = led_pkg::S_IDLE;
      end
      led_pkg::S_LINE_RD: begin
        state_next = led_pkg::S_LINE_OUT;
      end
      led_pkg::S_LINE_OUT: begin
        if (st.can_load && st.line_end) state_next = led_pkg::S_IDLE;
      end
      default: state_next = led_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.sel = led_pkg::SEL_CUR;
    rx_stall = (state != led_pkg::S_IDLE);
    unique case (state)
      led_pkg::S_IDLE: begin
        cmd.accept = rx_valid;
      end
      led_pkg::S_DECODE: begin
        cmd.len_dec = st.is_erase && !st.len_zero;
        cmd.to_lf   = st.is_cr && !st.crlf;
      end
      led_pkg::S_ECHO_CR: begin
        cmd.load = st.can_load;
        cmd.sel  = led_pkg::SEL_CR;
        cmd.last = st.crlf;
      end
      led_pkg::S_ECHO_C: begin
        cmd.load = st.can_load;
        cmd.sel  = led_pkg::SEL_CUR;
        cmd.last = !(st.is_lf && (st.room || !st.len_zero));
      end
      led_pkg::S_STORE: begin
        cmd.store      = 1'b1;
        cmd.line_start = 1'b1;
        cmd.clear      = st.is_lf && !st.room && st.len_zero;
      end
      led_pkg::S_ERASE_BS1: begin
        cmd.load = st.can_load;
        cmd.sel  = led_pkg::SEL_BS;
      end
      led_pkg::S_ERASE_SP: begin
        cmd.load = st.can_load;
        cmd.sel  = led_pkg::SEL_SP;
      end
      led_pkg::S_ERASE_BS2: begin
        cmd.load = st.can_load;
        cmd.sel  = led_pkg::SEL_BS;
        cmd.last = 1'b1;
      end
      led_pkg::S_LINE_RD: begin
        cmd.rd_en = 1'b1;
      end
      led_pkg::S_LINE_OUT: begin
        cmd.load    = st.can_load;
        cmd.sel     = led_pkg::SEL_LINE;
        cmd.last    = st.line_end;
        cmd.advance = st.can_load;
        cmd.rd_en   = st.can_load && !st.line_end;
        cmd.clear   = st.can_load && st.line_end;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/led_dp.sv =====
// Datapath of the line editor: config registers, held byte, line length,
// overflow mark, line store and output register. Depends on led_pkg, led_ram.
module led_dp #(
  parameter int LINE_MAX = led_pkg::LINE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     rx_byte,
  input  logic                           cfg_valid,
  input  logic [led_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [led_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           kind,
  output logic [7:0]                     out_byte,
  output logic                           truncated,
  output logic                           last,
  input  led_pkg::ctrl_cmd_t             cmd,
  output led_pkg::dp_status_t            st
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);

  logic                      echo_enable;
  logic                      cr_drop;
  logic [led_pkg::LIM_W-1:0] line_limit;
  logic [led_pkg::LIM_W-1:0] limit_eff;
  logic [7:0]                cur;
  logic [LW-1:0]             len;
  logic                      overflow_seen;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             rd_addr;
  logic [7:0]                rd_data;
  logic                      wr_en;
  logic [7:0]                sel_byte;

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
      cr_drop     <= 1'b0;
      line_limit  <= led_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        led_pkg::REG_ECHO_ENABLE: echo_enable <= cfg_data[0];
        led_pkg::REG_CR_DROP:     cr_drop     <= cfg_data[0];
        led_pkg::REG_LINE_LIMIT:  line_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the limit to the store depth
  assign limit_eff = (line_limit > led_pkg::LIM_W'(LINE_MAX)) ?
                     led_pkg::LIM_W'(LINE_MAX) : line_limit;

  // Hold the current byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= rx_byte;
    end else if (cmd.to_lf) begin
      cur <= led_pkg::CH_LF;
    end
  end

  // Line length and overflow mark
  assign wr_en = cmd.store && st.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      len           <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.clear) begin
        len <= '0;
      end else if (wr_en) begin
        len <= len + LW'(1);
      end else if (cmd.len_dec) begin
        len <= len - LW'(1);
      end
      if (cmd.clear) begin
        overflow_seen <= 1'b0;
      end else if (cmd.store && !st.room) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Line read index
  always_ff @(posedge clk) begin
    if (cmd.line_start) begin
      idx <= '0;
    end else if (cmd.advance) begin
      idx <= idx + AW'(1);
    end
  end

  // Prefetch the next entry while the current one is loaded
  assign rd_addr = cmd.advance ? idx + AW'(1) : idx;

  led_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len[AW-1:0]),
    .wdata (cur),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Select the result byte
  always_comb begin
    case (cmd.sel)
      led_pkg::SEL_BS:   sel_byte = led_pkg::CH_BS;
      led_pkg::SEL_SP:   sel_byte = led_pkg::CH_SP;
      led_pkg::SEL_CR:   sel_byte = led_pkg::CH_CR;
      led_pkg::SEL_LINE: sel_byte = rd_data;
      default:           sel_byte = cur;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= (cmd.sel == led_pkg::SEL_LINE);
      out_byte  <= sel_byte;
      truncated <= (cmd.sel == led_pkg::SEL_LINE) && overflow_seen;
      last      <= cmd.last;
    end
  end

  // Status to the sequencer
  always_comb begin
    st.is_esc   = (cur == led_pkg::CH_ESC);
    st.is_erase = (cur == led_pkg::CH_BS) || (cur == led_pkg::CH_DEL);
    st.is_cr    = (cur == led_pkg::CH_CR);
    st.is_lf    = (cur == led_pkg::CH_LF);
    st.len_zero = (len == '0);
    st.room     = (led_pkg::LIM_W'(len) < limit_eff);
    st.echo     = echo_enable;
    st.crlf     = cr_drop;
    st.can_load = !out_valid || !out_stall;
    st.line_end = ((LW'(idx) + LW'(1)) == len);
  end

endmodule

// ===== sv/line_editor_with_echo.sv =====
// Top level of the terminal line editor with echo.
// Depends on led_pkg, led_ctrl, led_dp (and led_ram below it).

// Takes one received byte at a time, echoes it if echo is enabled and
// builds a line of up to LINE_MAX bytes; on line feed the stored line
// streams out with a last mark. One byte is taken per pass of the
// sequencer: it is accepted, decoded, echoed as the mode asks and stored,
// and a completed line is read from the store and sent one stored byte at
// a time, all as the output register frees up. Progress is set by the
// single output register, which the sequencer fills one result a cycle
// while out_stall allows, and by the line store's registered read port.
// Configuration writes are always ready and must be issued only while no
// byte is in progress.
module line_editor_with_echo #(
  parameter int LINE_MAX = led_pkg::LINE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rx_valid,
  output logic                           rx_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           kind,
  output logic [7:0]                     out_byte,
  output logic                           truncated,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [led_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [led_pkg::CFG_DATA_W-1:0] cfg_data
);

  led_pkg::ctrl_cmd_t  cmd;
  led_pkg::dp_status_t st;

  // Registers take every write
  assign cfg_ready = 1'b1;

  led_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .st       (st),
    .cmd      (cmd)
  );

  led_dp #(
    .LINE_MAX (LINE_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kind      (kind),
    .out_byte  (out_byte),
    .truncated (truncated),
    .last      (last),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== sv/led_chk.sv =====
// Port-level checker for the line editor, bound to the top level.
// Depends on line_editor_with_echo_macros.svh.
`include "line_editor_with_echo_macros.svh"

module led_chk (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] out_byte,
  input logic       truncated,
  input logic       last
);

  // Hold a stalled result
  `LED_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last))

  // Echo results never carry the truncation flag
  `LED_ASSERT_NOW(a_echo_untrunc, out_valid && !kind, !truncated)

  // A transfer in busies the input side for the next cycle
  `LED_ASSERT_NEXT(a_rx_busy, rx_valid && !rx_stall, rx_stall)

  // Line bytes stream without gaps until the last one
  `LED_ASSERT_NEXT(a_line_stream, out_valid && !out_stall && kind && !last, out_valid && kind)

endmodule

bind line_editor_with_echo led_chk u_led_chk (.*);
